// ----- design/rmd_pkg.sv -----
package rmd_pkg;

    localparam int DATA_WIDTH_DEF = 64;   // default operand width
    localparam int FIELD_W        = 64;   // port width of every data field
    localparam int STATUS_W       = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    // per-stage control carried alongside the datapath
    typedef struct packed {
        logic valid;
        logic neg;   // result sign
        logic dz;    // divisor was zero
    } ctl_t;

endpackage

// ----- design/rmd_mul.sv -----
module rmd_mul #(
    parameter int DATA_WIDTH = rmd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rmd_pkg::FIELD_W-1:0]  multiplier,
    input  logic [rmd_pkg::FIELD_W-1:0]  multiplicand,
    input  logic [rmd_pkg::FIELD_W-1:0]  divisor,
    output rmd_pkg::ctl_t                ctl_o,
    output logic [2*DATA_WIDTH-1:0]      prod_o,
    output logic [DATA_WIDTH-1:0]        dmag_o
);
    import rmd_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;   // low half width
    localparam int L  = W - H;         // high half width
    localparam int PW = 2 * W;

    // stage A: magnitudes and signs
    logic [W-1:0] a_w, b_w, d_w;
    logic [W-1:0] a_reg, b_reg, d_a_reg;
    logic [W-1:0] a_next, b_next, d_a_next;
    ctl_t         ctl_a_reg, ctl_a_next;

    assign a_w = multiplier[W-1:0];
    assign b_w = multiplicand[W-1:0];
    assign d_w = divisor[W-1:0];

    always_comb
    begin
        a_next   = a_w[W-1] ? (~a_w + 1'b1) : a_w;
        b_next   = b_w[W-1] ? (~b_w + 1'b1) : b_w;
        d_a_next = d_w[W-1] ? (~d_w + 1'b1) : d_w;
        ctl_a_next.valid = in_valid;
        ctl_a_next.neg   = a_w[W-1] ^ b_w[W-1] ^ d_w[W-1];
        ctl_a_next.dz    = (d_w == '0);
    end

    // stage B: four partial products
    logic [2*H-1:0] p00_reg, p00_next;
    logic [W-1:0]   p01_reg, p01_next, p10_reg, p10_next;
    logic [2*L-1:0] p11_reg, p11_next;
    logic [W-1:0]   d_b_reg;
    ctl_t           ctl_b_reg;

    always_comb
    begin
        p00_next = (2*H)'(a_reg[H-1:0]) * (2*H)'(b_reg[H-1:0]);
        p01_next = W'(a_reg[H-1:0]) * W'(b_reg[W-1:H]);
        p10_next = W'(a_reg[W-1:H]) * W'(b_reg[H-1:0]);
        p11_next = (2*L)'(a_reg[W-1:H]) * (2*L)'(b_reg[W-1:H]);
    end

    // stage C: middle sum and low sum with rounding half
    logic [W:0]     mid_reg, mid_next;
    logic [2*H:0]   low_reg, low_next;
    logic [2*L-1:0] p11_c_reg;
    logic [W-1:0]   d_c_reg;
    ctl_t           ctl_c_reg;

    always_comb
    begin
        mid_next = (W+1)'(p01_reg) + (W+1)'(p10_reg);
        low_next = (2*H+1)'(p00_reg) + (2*H+1)'(d_b_reg >> 1);
    end

    // stage D: full product plus half divisor
    logic [PW-1:0] prod_reg, prod_next;
    logic [W-1:0]  d_d_reg;
    ctl_t          ctl_d_reg;

    always_comb
    begin
        prod_next = {p11_c_reg, {(2*H){1'b0}}}
                  + (PW'(mid_reg) << H)
                  + PW'(low_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            d_a_reg   <= d_a_next;
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            d_b_reg   <= d_a_reg;
            mid_reg   <= mid_next;
            low_reg   <= low_next;
            p11_c_reg <= p11_reg;
            d_c_reg   <= d_b_reg;
            prod_reg  <= prod_next;
            d_d_reg   <= d_c_reg;
        end
    end

    assign ctl_o  = ctl_d_reg;
    assign prod_o = prod_reg;
    assign dmag_o = d_d_reg;

endmodule

// ----- design/rmd_div_cell.sv -----
module rmd_div_cell #(
    parameter int DATA_WIDTH = rmd_pkg::DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  rmd_pkg::ctl_t           ctl_i,
    input  logic [DATA_WIDTH-1:0]   rem_i,
    input  logic [2*DATA_WIDTH-1:0] nq_i,
    input  logic [DATA_WIDTH-1:0]   d_i,
    output rmd_pkg::ctl_t           ctl_o,
    output logic [DATA_WIDTH-1:0]   rem_o,
    output logic [2*DATA_WIDTH-1:0] nq_o,
    output logic [DATA_WIDTH-1:0]   d_o
);
    import rmd_pkg::*;

    localparam int W = DATA_WIDTH;

    // nq: numerator bits still to go in the top, quotient bits entering at the bottom
    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           qbit;
    logic [W-1:0]   rem_reg, rem_next;
    logic [2*W-1:0] nq_reg, nq_next;
    logic [W-1:0]   d_reg;
    ctl_t           ctl_reg;

    always_comb
    begin
        trial    = {rem_i, nq_i[2*W-1]};
        diff     = trial - {1'b0, d_i};
        qbit     = (trial >= {1'b0, d_i});
        rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
        nq_next  = {nq_i[2*W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            d_reg   <= d_i;
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign nq_o  = nq_reg;
    assign d_o   = d_reg;

endmodule

// ----- design/rounded_multiply_divide_core.sv -----
// Rounded multiply-divide: quotient = round(multiplier * multiplicand / divisor),
// halves rounded away from zero, on DATA_WIDTH-bit two's complement operands
// (bits above DATA_WIDTH on the input ports are ignored).
// Input channel: in_valid/in_ready with multiplier, multiplicand, divisor.
// Output channel: out_valid/out_ready with quotient (sign-extended to 64 bits)
// and status (0 ok, 1 overflow, 2 divisor zero; quotient is zero if not ok).
// Pipeline: 4 multiply stages, one restoring-division cell per quotient bit,
// one output register.
// Throughput: one transaction per cycle unless stalled; every stage advances together.
// Stall: when out_ready is low with a result held, the whole pipeline freezes
// and in_ready drops in the same cycle; nothing in flight is lost.
// Reset: all valid flags clear, the pipeline is empty, in_ready is high.
module rounded_multiply_divide_core #(
    parameter int DATA_WIDTH = rmd_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rmd_pkg::FIELD_W-1:0]   multiplier,
    input  logic [rmd_pkg::FIELD_W-1:0]   multiplicand,
    input  logic [rmd_pkg::FIELD_W-1:0]   divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rmd_pkg::FIELD_W-1:0]   quotient,
    output logic [rmd_pkg::STATUS_W-1:0]  status
);
    import rmd_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int NCELL = 2 * W;   // one cell per quotient bit

    // global advance: output register empty or being drained
    logic en;

    ctl_t           ctl_c [NCELL+1];
    logic [W-1:0]   rem_c [NCELL+1];
    logic [2*W-1:0] nq_c  [NCELL+1];
    logic [W-1:0]   d_c   [NCELL+1];

    assign rem_c[0] = '0;

    // front end: sign split, partial products, product plus half divisor
    rmd_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .multiplier   (multiplier),
        .multiplicand (multiplicand),
        .divisor      (divisor),
        .ctl_o        (ctl_c[0]),
        .prod_o       (nq_c[0]),
        .dmag_o       (d_c[0])
    );

    // restoring division, one quotient bit per cell, MSB first
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        rmd_div_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ctl_i (ctl_c[i]),
            .rem_i (rem_c[i]),
            .nq_i  (nq_c[i]),
            .d_i   (d_c[i]),
            .ctl_o (ctl_c[i+1]),
            .rem_o (rem_c[i+1]),
            .nq_o  (nq_c[i+1]),
            .d_o   (d_c[i+1])
        );
    end

    // final check: range against the signed limit, then apply sign
    ctl_t                  ctl_f;
    logic [W-1:0]          q_hi, q_lo;
    logic [W-1:0]          limit;
    logic                  ovf;
    logic signed [W-1:0]   q_signed;
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]    quotient_reg, quotient_next;
    status_t               status_reg, status_next;

    assign ctl_f = ctl_c[NCELL];
    assign q_hi  = nq_c[NCELL][2*W-1:W];
    assign q_lo  = nq_c[NCELL][W-1:0];

    always_comb
    begin
        limit    = {1'b1, {(W-1){1'b0}}} - W'(!ctl_f.neg);
        ovf      = (q_hi != '0) || (q_lo > limit);
        q_signed = ctl_f.neg ? $signed(~q_lo + 1'b1) : $signed(q_lo);
        out_valid_next = ctl_f.valid;
        if (ctl_f.dz)
        begin
            status_next   = ST_DIV_ZERO;
            quotient_next = '0;
        end
        else if (ovf)
        begin
            status_next   = ST_OVERFLOW;
            quotient_next = '0;
        end
        else
        begin
            status_next   = ST_OK;
            quotient_next = FIELD_W'(q_signed);
        end
    end

    assign en = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg <= quotient_next;
            status_reg   <= status_next;
        end
    end

    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign quotient  = quotient_reg;
    assign status    = status_reg;

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import rmd_pkg::*;

    localparam int DW        = DATA_WIDTH_DEF;
    localparam int LATENCY   = 2 * DW + 5;
    // no transaction on either side for this many cycles means a hang
    localparam int IDLE_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [FIELD_W-1:0] multiplier;
    logic [FIELD_W-1:0] multiplicand;
    logic [FIELD_W-1:0] divisor;
    logic              out_valid;
    logic              out_ready;
    logic [FIELD_W-1:0] quotient;
    logic [STATUS_W-1:0] status;

    rounded_multiply_divide_core #(.DATA_WIDTH(DW)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .multiplier   (multiplier),
        .multiplicand (multiplicand),
        .divisor      (divisor),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quotient     (quotient),
        .status       (status)
    );

    typedef struct packed {
        logic [FIELD_W-1:0] quo;
        status_t            st;
    } rounded_quo_t;

    rounded_quo_t pending_quotients[$];
    int unsigned  mismatch_count;
    int unsigned  orphan_count;
    int unsigned  idle_cycles;
    bit           hold_off_req;   // sink is forced to stall while set

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predictor: exact 2*DW-bit signed product, magnitude rounding,
    // truncating divide, range check against DW-bit signed.
    function automatic rounded_quo_t predict_quotient(logic [FIELD_W-1:0] a_in,
                                                      logic [FIELD_W-1:0] b_in,
                                                      logic [FIELD_W-1:0] d_in);
        logic [DW-1:0]   a_w, b_w, d_w;
        logic            na, nb, nd, neg;
        logic [DW-1:0]   a_mag, b_mag, d_mag;
        logic [2*DW:0]   prod, num, q;
        logic [2*DW:0]   lim;
        rounded_quo_t    r;
        a_w = a_in[DW-1:0];
        b_w = b_in[DW-1:0];
        d_w = d_in[DW-1:0];
        na = a_w[DW-1];
        nb = b_w[DW-1];
        nd = d_w[DW-1];
        a_mag = na ? -a_w : a_w;
        b_mag = nb ? -b_w : b_w;
        d_mag = nd ? -d_w : d_w;
        if (d_mag == '0)
        begin
            r.quo = '0;
            r.st  = ST_DIV_ZERO;
            return r;
        end
        prod = {{(DW+1){1'b0}}, a_mag} * {{(DW+1){1'b0}}, b_mag};
        // rounding add happens in 2*DW bits, carry kept
        num  = prod + {{(DW+2){1'b0}}, d_mag[DW-1:1]};
        q    = num / {{(DW+1){1'b0}}, d_mag};
        neg  = (na ^ nb) ^ nd;
        lim  = ({{(2*DW){1'b0}}, 1'b1} << (DW - 1)) - (neg ? 0 : 1);
        if (q > lim)
        begin
            r.quo = '0;
            r.st  = ST_OVERFLOW;
        end
        else
        begin
            logic [DW-1:0] qw;
            qw = neg ? -q[DW-1:0] : q[DW-1:0];
            r.quo = {{(FIELD_W-DW){qw[DW-1]}}, qw};
            r.st  = ST_OK;
        end
        return r;
    endfunction

    // Random gap: mostly none or short, occasionally long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Send one transaction; prediction is pushed at acceptance.
    // Valid stays high after acceptance; the next send either replaces the
    // payload in the same step or drops valid for its gap.
    task automatic send_operands(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                 logic [FIELD_W-1:0] d, bit allow_gap);
        int unsigned gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        multiplier   <= a;
        multiplicand <= b;
        divisor      <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_quotients.push_back(predict_quotient(a, b, d));
    endtask

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand with a random magnitude class so that results stay in range often.
    function automatic logic [FIELD_W-1:0] rand_operand();
        int unsigned bits;
        logic [FIELD_W-1:0] v;
        bits = $urandom_range(1, 64);
        v = rand64();
        if (bits < 64)
            v = v & ((64'd1 << bits) - 1);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Output side: stall at random, check each transaction in order.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_quotients.size() == 0)
                begin
                    orphan_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("unexpected result q=%h st=%0d", quotient, status);
                end
                else
                begin
                    rounded_quo_t exp_r;
                    exp_r = pending_quotients.pop_front();
                    if (quotient !== exp_r.quo || status !== exp_r.st)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp q=%h st=%0d  got q=%h st=%0d",
                                     exp_r.quo, exp_r.st, quotient, status);
                    end
                end
            end
            if (hold_off_req)
                out_ready <= 1'b0;
            else if ($urandom_range(0, 99) < 75)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
        end
    end

    // Watchdog on transactions.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (hold_off_req)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Corners of every field, zero divisor, overflow, rounding ties, and
    // bits above DW (only meaningful when DW < 64).
    task automatic test_directed();
        logic [FIELD_W-1:0] max_p, min_n;
        max_p = 64'h7FFF_FFFF_FFFF_FFFF;
        min_n = 64'h8000_0000_0000_0000;
        send_operands(64'd5, 64'd7, 64'd0, 1);           // divisor zero
        send_operands(64'd0, 64'd0, 64'd0, 1);
        send_operands(64'd0, max_p, 64'd3, 1);           // zero product
        send_operands(64'd7, 64'd1, 64'd2, 1);           // 3.5 -> 4
        send_operands(-64'd7, 64'd1, 64'd2, 1);          // -3.5 -> -4
        send_operands(64'd7, 64'd1, -64'd2, 1);
        send_operands(64'd5, 64'd1, 64'd3, 1);           // 1.67 -> 2
        send_operands(64'd4, 64'd1, 64'd3, 1);           // 1.33 -> 1
        send_operands(max_p, max_p, max_p, 1);
        send_operands(min_n, min_n, min_n, 1);
        send_operands(min_n, 64'd1, 64'd1, 1);           // fits when negative
        send_operands(min_n, 64'd1, -64'd1, 1);          // +2^63 overflows
        send_operands(max_p, max_p, 64'd1, 1);           // overflow
        send_operands(max_p, 64'd2, 64'd2, 1);
        send_operands(min_n, min_n, 64'd1, 1);
        send_operands(min_n, max_p, min_n, 1);
        send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_operands(max_p, 64'd1, 64'd2, 1);           // half at top
        send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                      64'h0123_4567_89AB_CDEF, 1);
        send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'hFEDC_BA98_7654_3210, 1);
    endtask

    // Back-to-back and gapped random traffic.
    task automatic test_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            logic [FIELD_W-1:0] a, b, d;
            a = ($urandom_range(0, 9) == 0) ? rand64() : rand_operand();
            b = ($urandom_range(0, 9) == 0) ? rand64() : rand_operand();
            case ($urandom_range(0, 19))
                0:       d = '0;
                1:       d = 64'd1;
                2:       d = 64'd2;
                default: d = ($urandom_range(0, 4) == 0) ? rand64() : rand_operand();
            endcase
            send_operands(a, b, d, (i == count - 1) || ($urandom_range(0, 2) != 0));
        end
        in_valid <= 1'b0;
    endtask

    // Sink holds off long enough that the pipeline fills and in_ready drops.
    task automatic test_backpressure();
        fork
            begin
                hold_off_req = 1'b1;
                repeat (LATENCY + 80) @(posedge clk);
                hold_off_req = 1'b0;
            end
            begin
                for (int unsigned i = 0; i < LATENCY + 40; i++)
                    send_operands(rand_operand(), rand_operand(), rand_operand(), 0);
            end
        join
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        while (pending_quotients.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial
    begin
        mismatch_count = 0;
        orphan_count   = 0;
        hold_off_req   = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        multiplier   <= '0;
        multiplicand <= '0;
        divisor      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(1000);
        drain();

        if (mismatch_count == 0 && orphan_count == 0 && pending_quotients.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rmd_pkg.sv
design/rmd_mul.sv
design/rmd_div_cell.sv
design/rounded_multiply_divide_core.sv
verif/testbench.sv
